FILE: hw/rtl/llfp_pkg.sv
package llfp_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 14;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TICK_STEP     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_LIMIT = 4'd1;

   // register reset values
   localparam logic [7:0]  TICK_STEP_RESET     = 8'd25;
   localparam logic [13:0] TIMEOUT_LIMIT_RESET = 14'd10000;

   // result kinds
   localparam logic [1:0] KIND_LINE_START = 2'd0;
   localparam logic [1:0] KIND_TEXT       = 2'd1;
   localparam logic [1:0] KIND_LOST       = 2'd2;

   // input commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // framing characters
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_TILDE = 8'h7e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // silence timer
   localparam int              TIMER_W   = 15;
   localparam logic [TIMER_W-1:0] TIMER_MAX = 15'h7fff;

   // controller to datapath
   typedef struct packed {
      logic item_accept;
      logic load_text;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;
      logic rsp_last;
   } status_type;

endpackage

FILE: hw/rtl/llfp_if.sv
// input channel
interface llfp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

// result channel
interface llfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [1:0] row;
   logic [4:0] column;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output kind, output row, output column,
                   output char_code, output last, input ready);
   modport sink (input valid, input kind, input row, input column,
                 input char_code, input last, output ready);
endinterface

// configuration write channel
interface llfp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [llfp_pkg::CSR_INDEX_W-1:0]   index;
   logic [llfp_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lcd_line_frame_parser_top.sv
// a result is registered and appears the cycle after the transaction that causes it
// throughput: one input transaction per cycle while no results are pending
// a good frame or loss report holds input until its results drain; each text character
// passes a load state that moves the registered buffer read into the output register
// reset: synchronous, clears frame length, silence timer and lost flag, restores the
// registers to tick_step 25 and timeout_limit 10000; buffer content is undefined
module lcd_line_frame_parser_top #(
   parameter int LINE_CHARS = 20,
   parameter int ROWS       = 4
) (
   input  logic          clock,
   input  logic          reset,
   llfp_req_if.sink      req_if,
   llfp_rsp_if.source    rsp_if,
   llfp_csr_if.sink      csr_if
);

   llfp_pkg::cmd_type    cmd;
   llfp_pkg::status_type status;

   // configuration writes are always taken
   assign csr_if.ready = 1'b1;

   llfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   llfp_datapath #(
      .LINE_CHARS (LINE_CHARS),
      .ROWS       (ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_cmd       (req_if.cmd),
      .req_rx_byte   (req_if.rx_byte),
      .csr_valid     (csr_if.valid),
      .csr_index     (csr_if.index),
      .csr_data      (csr_if.data),
      .rsp_kind      (rsp_if.kind),
      .rsp_row       (rsp_if.row),
      .rsp_column    (rsp_if.column),
      .rsp_char_code (rsp_if.char_code),
      .rsp_last      (rsp_if.last)
   );

endmodule

FILE: hw/rtl/llfp_ctrl.sv
module llfp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  llfp_pkg::status_type status,
   output llfp_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_OUT  = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // handshake decode
   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign accept          = req_valid && req_ready;
   assign cmd.item_accept = accept;
   assign cmd.load_text   = (state_ff == S_LOAD);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && status.emit) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = status.rsp_last ? S_IDLE : S_LOAD;
         end
         S_LOAD: begin
            state_in = S_OUT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/llfp_datapath.sv
module llfp_datapath #(
   parameter int LINE_CHARS = 20,
   parameter int ROWS       = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  llfp_pkg::cmd_type                  cmd,
   output llfp_pkg::status_type               status,
   input  logic                               req_cmd,
   input  logic [7:0]                         req_rx_byte,
   input  logic                               csr_valid,
   input  logic [llfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [llfp_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [1:0]                         rsp_kind,
   output logic [1:0]                         rsp_row,
   output logic [4:0]                         rsp_column,
   output logic [7:0]                         rsp_char_code,
   output logic                               rsp_last
);

   localparam int BUF_DEPTH = LINE_CHARS + 3;
   localparam int LEN_OVER  = LINE_CHARS + 4;
   localparam int LEN_W     = $clog2(LEN_OVER + 1);
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(LINE_CHARS + 1);
   localparam int TW        = llfp_pkg::TIMER_W;
   localparam logic [7:0] ROW_END = 8'(int'(llfp_pkg::CHAR_ZERO) + ROWS);

   // frame buffer
   logic [7:0] buf_mem [BUF_DEPTH];
   logic [7:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   // state and configuration
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       second_ff, second_in;
   logic [TW-1:0]    timer_ff, timer_in;
   logic             lost_ff, lost_in;
   logic [7:0]       step_ff, step_in;
   logic [13:0]      limit_ff, limit_in;

   // emission bookkeeping
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] text_ff, text_in;
   logic [1:0]       row_ff, row_in;

   // result register
   logic [1:0] kind_ff, kind_in;
   logic [1:0] orow_ff, orow_in;
   logic [4:0] col_ff, col_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;

   // item decode
   logic             is_tick, is_byte, is_close, is_store, can_store;
   logic             frame_good, timed_out, lost_fire;
   logic [LEN_W-1:0] text_raw;
   logic [CNT_W-1:0] text_len;
   logic [TW:0]      timer_sum;
   logic [CNT_W-1:0] idx_next;

   assign is_tick   = (req_cmd == llfp_pkg::CMD_TICK);
   assign is_byte   = (req_cmd == llfp_pkg::CMD_BYTE) && (req_rx_byte != llfp_pkg::CHAR_NUL);
   assign is_close  = is_byte && (req_rx_byte == llfp_pkg::CHAR_HASH);
   assign is_store  = is_byte && !is_close;
   assign can_store = (len_ff < LEN_W'(BUF_DEPTH));

   // frame check at close
   assign frame_good = (len_ff >= LEN_W'(2)) && (len_ff <= LEN_W'(BUF_DEPTH))
                       && (first_ff == llfp_pkg::CHAR_TILDE)
                       && (second_ff >= llfp_pkg::CHAR_ZERO) && (second_ff < ROW_END);
   assign text_raw   = len_ff - LEN_W'(2);
   assign text_len   = (text_raw > LEN_W'(LINE_CHARS)) ? CNT_W'(LINE_CHARS)
                                                      : text_raw[CNT_W-1:0];

   // silence timer
   assign timed_out = (timer_ff >= TW'(limit_ff));
   assign lost_fire = is_tick && timed_out && !lost_ff;
   assign timer_sum = {1'b0, timer_ff} + (TW + 1)'(step_ff);

   assign idx_next = idx_ff + CNT_W'(1);
   assign rd_addr  = ADDR_W'(idx_ff) + ADDR_W'(2);

   assign status.emit     = cmd.item_accept && ((is_close && frame_good) || lost_fire);
   assign status.rsp_last = last_ff;

   // next state
   always_comb begin
      len_in    = len_ff;
      first_in  = first_ff;
      second_in = second_ff;
      timer_in  = timer_ff;
      lost_in   = lost_ff;
      step_in   = step_ff;
      limit_in  = limit_ff;
      idx_in    = idx_ff;
      text_in   = text_ff;
      row_in    = row_ff;
      kind_in   = kind_ff;
      orow_in   = orow_ff;
      col_in    = col_ff;
      char_in   = char_ff;
      last_in   = last_ff;

      // register writes
      if (csr_valid) begin
         if (csr_index == llfp_pkg::REG_TICK_STEP) step_in = csr_data[7:0];
         if (csr_index == llfp_pkg::REG_TIMEOUT_LIMIT) limit_in = csr_data[13:0];
      end

      if (cmd.item_accept) begin
         // byte into buffer
         if (is_store) begin
            if (can_store) begin
               len_in = len_ff + LEN_W'(1);
               if (len_ff == LEN_W'(0)) first_in = req_rx_byte;
               if (len_ff == LEN_W'(1)) second_in = req_rx_byte;
            end else begin
               len_in = LEN_W'(LEN_OVER);
            end
         end
         // frame close
         if (is_close) begin
            len_in = '0;
            if (frame_good) begin
               timer_in = '0;
               lost_in  = 1'b0;
               idx_in   = '0;
               text_in  = text_len;
               row_in   = 2'(second_ff - llfp_pkg::CHAR_ZERO);
               kind_in  = llfp_pkg::KIND_LINE_START;
               orow_in  = 2'(second_ff - llfp_pkg::CHAR_ZERO);
               col_in   = '0;
               char_in  = '0;
               last_in  = (text_len == '0);
            end
         end
         // timer tick
         if (is_tick) begin
            if (timed_out) begin
               if (!lost_ff) begin
                  lost_in = 1'b1;
                  kind_in = llfp_pkg::KIND_LOST;
                  orow_in = '0;
                  col_in  = '0;
                  char_in = '0;
                  last_in = 1'b1;
               end
            end else if (timer_sum[TW]) begin
               timer_in = llfp_pkg::TIMER_MAX;
            end else begin
               timer_in = timer_sum[TW-1:0];
            end
         end
      end

      // next text character
      if (cmd.load_text) begin
         kind_in = llfp_pkg::KIND_TEXT;
         orow_in = row_ff;
         col_in  = 5'(idx_ff);
         char_in = rd_data_ff;
         last_in = (idx_next == text_ff);
         idx_in  = idx_next;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         timer_ff <= '0;
         lost_ff  <= 1'b0;
         step_ff  <= llfp_pkg::TICK_STEP_RESET;
         limit_ff <= llfp_pkg::TIMEOUT_LIMIT_RESET;
      end else begin
         len_ff   <= len_in;
         timer_ff <= timer_in;
         lost_ff  <= lost_in;
         step_ff  <= step_in;
         limit_ff <= limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
      idx_ff    <= idx_in;
      text_ff   <= text_in;
      row_ff    <= row_in;
      kind_ff   <= kind_in;
      orow_ff   <= orow_in;
      col_ff    <= col_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   // buffer write and registered read
   always_ff @(posedge clock) begin
      if (cmd.item_accept && is_store && can_store) begin
         buf_mem[len_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      rd_data_ff <= buf_mem[rd_addr];
   end

   assign rsp_kind      = kind_ff;
   assign rsp_row       = orow_ff;
   assign rsp_column    = col_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: dv/tb_lcd_line_frame_parser_top.sv
module tb_lcd_line_frame_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_CHARS      = 20;
   localparam int ROWS            = 4;
   localparam int FRAME_DEPTH     = LINE_CHARS + 3;
   localparam int LEN_OVERLONG    = LINE_CHARS + 4;
   localparam int ITEMS_PER_PHASE = 22;
   localparam int SETTLE_CYCLES   = 6;
   localparam int DRAIN_CYCLES    = 60;
   localparam int LONG_TICKS_MAX  = 120;
   localparam int CYCLE_LIMIT     = 1000000;

   // index outside the register map, writes to it must be ignored
   localparam logic [llfp_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 4'd9;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] row;
      logic [4:0] column;
      logic [7:0] char_code;
      logic       last;
   } line_update_type;

   // display update predictor and scoreboard
   class line_update_scoreboard;
      line_update_type pending_updates[$];
      logic [7:0]   frame_bytes[FRAME_DEPTH];
      int unsigned  frame_len;
      int unsigned  silence_ms;
      bit           lost_reported;
      logic [7:0]   tick_step;
      logic [13:0]  timeout_limit;
      int unsigned  errors;
      int unsigned  updates_checked;
      int unsigned  frames_shown;
      int unsigned  lost_reports;

      function new();
         frame_len       = 0;
         silence_ms      = 0;
         lost_reported   = 1'b0;
         tick_step       = llfp_pkg::TICK_STEP_RESET;
         timeout_limit   = llfp_pkg::TIMEOUT_LIMIT_RESET;
         errors          = 0;
         updates_checked = 0;
         frames_shown    = 0;
         lost_reports    = 0;
      endfunction

      function void write_reg(logic [llfp_pkg::CSR_INDEX_W-1:0] index,
                              logic [llfp_pkg::CSR_DATA_W-1:0] data);
         if (index == llfp_pkg::REG_TICK_STEP) begin
            tick_step = data[7:0];
         end else if (index == llfp_pkg::REG_TIMEOUT_LIMIT) begin
            timeout_limit = data[13:0];
         end
      endfunction

      function void add_update(logic [1:0] kind, logic [1:0] row, logic [4:0] column,
                               logic [7:0] char_code, logic last);
         line_update_type u;
         u.kind      = kind;
         u.row       = row;
         u.column    = column;
         u.char_code = char_code;
         u.last      = last;
         pending_updates.push_back(u);
      endfunction

      // advance the state by one accepted input transaction
      function void note_transaction(logic cmd, logic [7:0] rx);
         int unsigned len;
         int unsigned text;
         logic [1:0]  row;
         if (cmd == llfp_pkg::CMD_TICK) begin
            // timer at the limit reports the loss once, otherwise it counts up
            if (silence_ms >= timeout_limit) begin
               if (!lost_reported) begin
                  lost_reported = 1'b1;
                  lost_reports++;
                  add_update(llfp_pkg::KIND_LOST, 2'd0, 5'd0, 8'd0, 1'b1);
               end
            end else begin
               silence_ms += tick_step;
               if (silence_ms > llfp_pkg::TIMER_MAX) silence_ms = llfp_pkg::TIMER_MAX;
            end
         end else if (rx == llfp_pkg::CHAR_NUL) begin
            // zero bytes leave everything untouched
         end else if (rx == llfp_pkg::CHAR_HASH) begin
            // closing byte: empty the buffer, show the line if the frame is sound
            len       = frame_len;
            frame_len = 0;
            if (len >= 2 && len <= FRAME_DEPTH && frame_bytes[0] == llfp_pkg::CHAR_TILDE &&
                frame_bytes[1] >= llfp_pkg::CHAR_ZERO &&
                frame_bytes[1] < llfp_pkg::CHAR_ZERO + ROWS) begin
               row  = 2'(frame_bytes[1] - llfp_pkg::CHAR_ZERO);
               text = len - 2;
               if (text > LINE_CHARS) text = LINE_CHARS;
               add_update(llfp_pkg::KIND_LINE_START, row, 5'd0, 8'd0, text == 0);
               for (int i = 0; i < text; i++) begin
                  add_update(llfp_pkg::KIND_TEXT, row, 5'(i), frame_bytes[2 + i],
                             i + 1 == text);
               end
               silence_ms    = 0;
               lost_reported = 1'b0;
               frames_shown++;
            end
         end else if (frame_len < FRAME_DEPTH) begin
            frame_bytes[frame_len] = rx;
            frame_len++;
         end else begin
            frame_len = LEN_OVERLONG;
         end
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_update(line_update_type got);
         line_update_type want;
         updates_checked++;
         if (pending_updates.size() == 0) begin
            errors++;
            $display("%0t: unexpected line update: expected none, actual kind %0d row %0d",
                     $time, got.kind, got.row, " column %0d char %h last %0d",
                     got.column, got.char_code, got.last);
         end else begin
            want = pending_updates.pop_front();
            if (got.kind !== want.kind || got.row !== want.row ||
                got.column !== want.column || got.char_code !== want.char_code ||
                got.last !== want.last) begin
               errors++;
               $display("%0t: line update mismatch: expected kind %0d row %0d column %0d",
                        $time, want.kind, want.row, want.column,
                        " char %h last %0d, actual kind %0d row %0d column %0d",
                        want.char_code, want.last, got.kind, got.row, got.column,
                        " char %h last %0d", got.char_code, got.last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   llfp_req_if req_if ();
   llfp_rsp_if rsp_if ();
   llfp_csr_if csr_if ();

   line_update_scoreboard updates_sb;
   line_update_type       seen_update;
   bit                    req_held;
   bit                    req_burst;
   bit                    rsp_burst;
   int                    rsp_hold;
   int unsigned           items_sent;
   int unsigned           settings_used;
   int unsigned           cycle_count;

   lcd_line_frame_parser_top #(
      .LINE_CHARS (LINE_CHARS),
      .ROWS       (ROWS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d updates outstanding", $time,
                  updates_sb.pending_updates.size());
         $display("FAIL");
         $finish;
      end
   end

   // result side: check each transaction, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_update.kind      = rsp_if.kind;
         seen_update.row       = rsp_if.row;
         seen_update.column    = rsp_if.column;
         seen_update.char_code = rsp_if.char_code;
         seen_update.last      = rsp_if.last;
         updates_sb.check_update(seen_update);
         if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
         rsp_hold = rsp_burst ? 0 : $urandom_range(0, 13);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_if.ready <= (rsp_hold == 0);
   end

   function automatic logic [7:0] text_char();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == llfp_pkg::CHAR_HASH);
      return b;
   endfunction

   function automatic logic [7:0] valid_row_char();
      return 8'(llfp_pkg::CHAR_ZERO + $urandom_range(0, ROWS - 1));
   endfunction

   // one input transaction after a random gap; valid stays up if the next follows at once
   task automatic send_item(input logic cmd, input logic [7:0] rx);
      int gap;
      if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         if (req_held) req_if.valid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cmd     <= cmd;
      req_if.rx_byte <= rx;
      req_held = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      updates_sb.note_transaction(cmd, rx);
      if (!(cmd == llfp_pkg::CMD_BYTE && rx == llfp_pkg::CHAR_NUL)) items_sent++;
   endtask

   task automatic release_req();
      if (req_held) req_if.valid <= 1'b0;
      req_held = 1'b0;
   endtask

   task automatic wait_drained();
      while (updates_sb.pending_updates.size() != 0) @(posedge clock);
   endtask

   // frame with a lead byte, a row byte and random text, zero bytes sprinkled in
   task automatic send_frame(input logic [7:0] lead, input logic [7:0] row_char,
                             input int text_len);
      send_item(llfp_pkg::CMD_BYTE, lead);
      send_item(llfp_pkg::CMD_BYTE, row_char);
      for (int i = 0; i < text_len; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(llfp_pkg::CMD_BYTE, llfp_pkg::CHAR_NUL);
         send_item(llfp_pkg::CMD_BYTE, text_char());
      end
      send_item(llfp_pkg::CMD_BYTE, llfp_pkg::CHAR_HASH);
   endtask

   task automatic write_csr(input logic [llfp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [llfp_pkg::CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      updates_sb.write_reg(index, data);
   endtask

   // new register setting, only once the block has gone quiet
   task automatic apply_settings(input logic [llfp_pkg::CSR_DATA_W-1:0] step_data,
                                 input logic [llfp_pkg::CSR_DATA_W-1:0] limit_data);
      release_req();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(llfp_pkg::REG_TICK_STEP, step_data);
      write_csr(REG_UNUSED, 14'($urandom_range(0, 16383)));
      write_csr(llfp_pkg::REG_TIMEOUT_LIMIT, limit_data);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   // random traffic, mostly well-formed frames
   task automatic run_random(input int unsigned count);
      int unsigned goal;
      int          pick;
      int          n;
      int          len;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            n   = $urandom_range(0, 9);
            len = n < 6 ? $urandom_range(0, 5) :
                  n < 9 ? $urandom_range(6, LINE_CHARS - 1) : LINE_CHARS;
            send_frame(llfp_pkg::CHAR_TILDE,
                       $urandom_range(0, 9) == 0 ? text_char() : valid_row_char(), len);
         end else if (pick < 60) begin
            send_frame(llfp_pkg::CHAR_TILDE, valid_row_char(),
                       $urandom_range(LINE_CHARS + 1, LINE_CHARS + 5));
         end else if (pick < 70) begin
            send_frame(text_char(), text_char(), $urandom_range(0, 4));
         end else if (pick < 88) begin
            // tick bursts, now and then long enough to run into the timeout
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) begin
               n = updates_sb.tick_step == 0 ? 3 :
                   updates_sb.timeout_limit / updates_sb.tick_step + 2;
               if (n > LONG_TICKS_MAX) n = LONG_TICKS_MAX;
            end
            repeat (n) send_item(llfp_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 3))
               send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // stimulus
   initial begin
      logic [7:0] opening[] = '{
         llfp_pkg::CHAR_TILDE, llfp_pkg::CHAR_ZERO, 8'h01, llfp_pkg::CHAR_NUL, 8'hff,
         llfp_pkg::CHAR_HASH,
         llfp_pkg::CHAR_TILDE, 8'(llfp_pkg::CHAR_ZERO + 3), llfp_pkg::CHAR_HASH,
         llfp_pkg::CHAR_TILDE, 8'(llfp_pkg::CHAR_ZERO + ROWS), llfp_pkg::CHAR_HASH,
         llfp_pkg::CHAR_TILDE, 8'(llfp_pkg::CHAR_ZERO - 1), llfp_pkg::CHAR_HASH,
         8'h41, 8'(llfp_pkg::CHAR_ZERO + 1), llfp_pkg::CHAR_HASH,
         llfp_pkg::CHAR_TILDE, llfp_pkg::CHAR_HASH,
         llfp_pkg::CHAR_HASH};

      updates_sb     = new();
      req_held       = 1'b0;
      req_burst      = 1'b0;
      items_sent     = 0;
      settings_used  = 1;
      req_if.valid   = 1'b0;
      req_if.cmd     = llfp_pkg::CMD_BYTE;
      req_if.rx_byte = llfp_pkg::CHAR_NUL;
      csr_if.valid   = 1'b0;
      csr_if.index   = llfp_pkg::REG_TICK_STEP;
      csr_if.data    = '0;
      reset          = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: text extremes, empty text, bad rows, bad start, short frames, ticks
      foreach (opening[i]) send_item(llfp_pkg::CMD_BYTE, opening[i]);
      repeat (2) send_item(llfp_pkg::CMD_TICK, 8'hff);
      run_random(ITEMS_PER_PHASE);

      // zero step and zero limit: any tick finds the timer at the limit and reports the loss unless already reported
      apply_settings(14'h3f00, 14'd0);
      repeat (2) send_item(llfp_pkg::CMD_TICK, 8'h00);
      run_random(ITEMS_PER_PHASE);

      apply_settings(14'd255, 14'd16383);
      run_random(ITEMS_PER_PHASE);

      apply_settings(14'd1, 14'd1);
      run_random(ITEMS_PER_PHASE);

      apply_settings(14'd0, 14'd5);
      run_random(ITEMS_PER_PHASE);

      apply_settings(14'($urandom_range(1, 255)), 14'($urandom_range(1, 2000)));
      run_random(ITEMS_PER_PHASE);

      apply_settings(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
      run_random(ITEMS_PER_PHASE);

      // wrap up
      release_req();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d input transactions under %0d register settings",
               items_sent, settings_used);
      $display("checked %0d line updates: %0d frames shown, %0d connection-lost reports",
               updates_sb.updates_checked, updates_sb.frames_shown, updates_sb.lost_reports);
      if (updates_sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
